>>> rtl/grou_pkg.sv
// Shared constants and types of the ratio-of-uniforms normal sampler.
// No dependencies; imported by the top level, grou_log, grou_div and the testbench.
`default_nettype none

package grou_pkg;

    // Fixed-point constants, all Q.30 unless named otherwise
    localparam logic [30:0] K_Q30   = 31'd1842111473;   // 1.7156
    localparam logic [29:0] S_Q30   = 30'd483045308;    // 0.449871
    localparam logic [29:0] T_Q30   = 30'd415103221;    // 0.386595
    localparam logic [27:0] A_Q30   = 28'd210453398;    // 0.19600
    localparam logic [28:0] B_Q30   = 29'd273503517;    // 0.25472
    localparam logic signed [33:0] R1_Q30 = 34'sd296320531;  // 0.27597
    localparam logic signed [33:0] R2_Q30 = 34'sd298994148;  // 0.27846
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam int unsigned OUT_W  = 21;
    localparam int unsigned QUO_W  = 22;
    localparam int unsigned LOG_STAGES = 30;

    localparam logic [QUO_W-1:0] QUO_SAT     = 22'h200000;
    localparam logic [QUO_W-1:0] OUT_POS_MAX = 22'h0FFFFF;
    localparam logic [QUO_W-1:0] OUT_NEG_MAX = 22'h100000;

    // Everything that rides along the logarithm pipeline
    typedef struct packed {
        logic        neg;
        logic        sq_acc;
        logic        sq_rej;
        logic [4:0]  lead;
        logic [29:0] usq;
        logic [59:0] vsq;
        logic [31:0] num;
        logic [31:0] den;
    } log_side_t;

endpackage

`default_nettype wire

>>> rtl/grou_if.sv
// Handshake channels of the sampler: candidate pair in, normal deviate out.
// No dependencies.
`default_nettype none

interface grou_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] uniform_u;
    logic [31:0] uniform_v;

    modport source (output valid, output uniform_u, output uniform_v, input ready);
    modport sink   (input valid, input uniform_u, input uniform_v, output ready);
endinterface

interface grou_out_if;
    logic               valid;
    logic               ready;
    logic signed [20:0] normal_sample;

    modport source (output valid, output normal_sample, input ready);
    modport sink   (input valid, input normal_sample, output ready);
endinterface

`default_nettype wire

>>> rtl/gaussian_ratio_of_uniforms.sv
// Top level of the ratio-of-uniforms normal sampler.
// Depends on grou_pkg, grou_if, grou_log and grou_div.
`default_nettype none

// Takes one candidate pair of 32-bit uniform words per clock while the output
// buffer has room, and emits a standard normal deviate v/u in signed Q4.16
// (SAMPLE_FRACTION_BITS fraction bits) for each pair that passes the
// acceptance test; rejected pairs and pairs whose u word is zero produce
// nothing. The datapath is a fixed pipeline: six stages form v, u and the
// quadratic squeeze, thirty stages run the log2 squaring chain (one 31x31
// multiply each), five stages finish -4 u^2 ln u and the exact test, and
// twenty-three stages perform the restoring division (a seeding stage, then
// one quotient bit each). Sustained rate is one pair per cycle while the
// output buffer is not full; every stage holds one pair. A two-word output
// buffer decouples the sink: the pipeline only stops while that buffer is full.

module gaussian_ratio_of_uniforms #(
    parameter int SAMPLE_FRACTION_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    grou_in_if.sink    pairs,
    grou_out_if.source samples
);
    import grou_pkg::*;

    // unsigned product of two Q.30 magnitudes, rounded half up
    function automatic logic [31:0] rmul30(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = {32'd0, a} * {32'd0, b} + 64'h2000_0000;
        return p[61:30];
    endfunction

    logic en;

    // ---------------- stage 1: capture, form |V - 1/2| ----------------
    logic        v1_reg;
    logic [31:0] u1_reg;
    logic [31:0] dmag1_reg;
    logic        neg1_reg;
    logic [31:0] dmag1_next;

    assign dmag1_next = pairs.uniform_v[31] ? {1'b0, pairs.uniform_v[30:0]}
                                            : 32'h8000_0000 - pairs.uniform_v;

    // ---------------- stage 2: scale by 1.7156, find leading one ----------------
    logic        v2_reg;
    logic [61:0] vm62_2_reg;
    logic [4:0]  lead2_reg;
    logic [31:0] u2_reg;
    logic        neg2_reg;
    logic [62:0] vm62_next;
    logic [4:0]  lead2_next;

    always_comb
    begin
        vm62_next  = {31'd0, dmag1_reg} * {32'd0, K_Q30};
        lead2_next = '0;
        for (int i = 0; i < 32; i++)
            if (u1_reg[i])
                lead2_next = 5'(i);
    end

    // ---------------- stage 3: round v, form x, y, normalize u ----------------
    logic               v3_reg;
    logic [31:0]        vm32_3_reg;
    logic [29:0]        vm30_3_reg;
    logic [30:0]        y3_reg;
    logic signed [30:0] x3_reg;
    logic [30:0]        m3_reg;
    logic [4:0]         lead3_reg;
    logic [31:0]        u3_reg;
    logic               neg3_reg;
    logic [29:0]        usq3_reg;
    logic [62:0]        r32_sum;
    logic [62:0]        r30_sum;
    logic [62:0]        mshift;
    logic [59:0]        uu;
    logic [29:0]        vm30_next;

    always_comb
    begin
        r32_sum   = {1'b0, vm62_2_reg} + 63'h2000_0000;
        r30_sum   = {1'b0, vm62_2_reg} + 63'h8000_0000;
        vm30_next = r30_sum[61:32];
        mshift    = {u2_reg, 31'd0} >> ({1'b0, lead2_reg} + 6'd1);
        uu        = {30'd0, u2_reg[31:2]} * {30'd0, u2_reg[31:2]};
    end

    // ---------------- stage 4: squeeze products ----------------
    logic        v4_reg;
    logic [29:0] pa4_reg;
    logic [29:0] pbm4_reg;
    logic        xneg4_reg;
    logic [29:0] xx4_reg;
    logic [59:0] vsq4_reg;
    logic [30:0] y4_reg;
    logic [30:0] m4_reg;
    logic [4:0]  lead4_reg;
    logic [31:0] u4_reg;
    logic        neg4_reg;
    logic [29:0] usq4_reg;
    logic [31:0] vm32_4_reg;
    logic [30:0] xmag;
    logic [31:0] pa_next;
    logic [31:0] pbm_next;
    logic [31:0] xx_next;
    logic [59:0] vsq_next;

    always_comb
    begin
        xmag     = x3_reg[30] ? 31'(-x3_reg) : 31'(x3_reg);
        pa_next  = rmul30(32'(A_Q30), 32'(y3_reg));
        pbm_next = rmul30(32'(B_Q30), 32'(xmag));
        xx_next  = rmul30(32'(xmag), 32'(xmag));
        vsq_next = {30'd0, vm30_3_reg} * {30'd0, vm30_3_reg};
    end

    // ---------------- stage 5: y * (A*y - B*x) ----------------
    logic        v5_reg;
    logic [29:0] pym5_reg;
    logic        pyneg5_reg;
    logic [29:0] xx5_reg;
    logic [59:0] vsq5_reg;
    logic [30:0] m5_reg;
    logic [4:0]  lead5_reg;
    logic [31:0] u5_reg;
    logic        neg5_reg;
    logic [29:0] usq5_reg;
    logic [31:0] vm32_5_reg;
    logic [31:0] inner;
    logic [31:0] imag;
    logic [31:0] pym_next;

    always_comb
    begin
        inner    = xneg4_reg ? {2'd0, pa4_reg} + {2'd0, pbm4_reg}
                             : {2'd0, pa4_reg} - {2'd0, pbm4_reg};
        imag     = inner[31] ? -inner : inner;
        pym_next = rmul30(32'(y4_reg), imag);
    end

    // ---------------- stage 6: squeeze decision ----------------
    logic        v6_reg;
    logic [30:0] m6_reg;
    log_side_t   side6_reg;
    logic signed [33:0] q_sum;

    assign q_sum = pyneg5_reg ? $signed({4'd0, xx5_reg}) - $signed({4'd0, pym5_reg})
                              : $signed({4'd0, xx5_reg}) + $signed({4'd0, pym5_reg});

    // ---------------- log2 squaring chain ----------------
    logic        lv_out;
    logic [29:0] lf_out;
    log_side_t   lside_out;

    grou_log u_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v6_reg),
        .mant      (m6_reg),
        .in_side   (side6_reg),
        .out_valid (lv_out),
        .frac      (lf_out),
        .out_side  (lside_out)
    );

    // ---------------- L1..L5: -4 u^2 ln u and exact test ----------------
    logic        e1_v_reg, e2_v_reg, e3_v_reg, e4_v_reg, e5_v_reg;
    log_side_t   e1_side_reg, e2_side_reg, e3_side_reg, e4_side_reg;
    logic [37:0] e1_a_reg;
    logic [31:0] e1_b_reg;
    logic [35:0] e2_nl_reg;
    logic [47:0] e3_plo_reg;
    logic [47:0] e3_phi_reg;
    logic [65:0] e4_sum_reg;
    logic [31:0] e5_num_reg;
    logic [31:0] e5_den_reg;
    logic        e5_neg_reg;
    logic [37:0] a_next;
    logic [61:0] fb;
    logic [37:0] nl_diff;
    logic        exact;
    logic        accept;

    always_comb
    begin
        a_next  = {32'd0, 6'd32 - {1'b0, lside_out.lead}} * {6'd0, LN2_Q32};
        fb      = {32'd0, lf_out} * {30'd0, LN2_Q32};
        nl_diff = e1_a_reg - {6'd0, e1_b_reg};
        exact   = {8'd0, e4_side_reg.vsq} <= {e4_sum_reg, 2'b00};
        accept  = e4_side_reg.sq_acc || (!e4_side_reg.sq_rej && exact);
    end

    // ---------------- divider ----------------
    logic        dv_out;
    logic        dneg_out;
    logic        dsat_out;
    logic [21:0] dquo_out;

    grou_div #(
        .FRAC_BITS (SAMPLE_FRACTION_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e5_v_reg),
        .num       (e5_num_reg),
        .den       (e5_den_reg),
        .in_neg    (e5_neg_reg),
        .out_valid (dv_out),
        .out_neg   (dneg_out),
        .out_sat   (dsat_out),
        .quo       (dquo_out)
    );

    // round to nearest (ties away), saturate, apply sign
    logic [21:0]        res_rnd;
    logic [21:0]        res_mag;
    logic signed [20:0] sample_next;

    always_comb
    begin
        res_rnd = dsat_out ? QUO_SAT : {1'b0, dquo_out[21:1]} + {21'd0, dquo_out[0]};
        if (dneg_out)
            res_mag = (res_rnd > OUT_NEG_MAX) ? OUT_NEG_MAX : res_rnd;
        else
            res_mag = (res_rnd > OUT_POS_MAX) ? OUT_POS_MAX : res_rnd;
        sample_next = dneg_out ? $signed(21'(-res_mag)) : $signed(res_mag[20:0]);
    end

    // ---------------- output buffer: two words ----------------
    logic               [20:0] buf_reg [2];
    logic                      wr_ptr_reg;
    logic                      rd_ptr_reg;
    logic [1:0]                cnt_reg;
    logic                      push;
    logic                      pop;

    assign en     = (cnt_reg != 2'd2);
    assign push   = en && dv_out;
    assign pop    = samples.valid && samples.ready;

    assign pairs.ready           = en;
    assign samples.valid         = (cnt_reg != 2'd0);
    assign samples.normal_sample = $signed(buf_reg[rd_ptr_reg]);

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            e1_v_reg <= 1'b0;
            e2_v_reg <= 1'b0;
            e3_v_reg <= 1'b0;
            e4_v_reg <= 1'b0;
            e5_v_reg <= 1'b0;
        end
        else if (en)
        begin
            // drop a zero u word right away
            v1_reg   <= pairs.valid && (pairs.uniform_u != 32'd0);
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            e1_v_reg <= lv_out;
            e2_v_reg <= e1_v_reg;
            e3_v_reg <= e2_v_reg;
            e4_v_reg <= e3_v_reg;
            // drop rejected pairs before the divider
            e5_v_reg <= e4_v_reg && accept;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg     <= pairs.uniform_u;
            dmag1_reg  <= dmag1_next;
            neg1_reg   <= !pairs.uniform_v[31];

            vm62_2_reg <= vm62_next[61:0];
            lead2_reg  <= lead2_next;
            u2_reg     <= u1_reg;
            neg2_reg   <= neg1_reg;

            vm32_3_reg <= r32_sum[61:30];
            vm30_3_reg <= vm30_next;
            y3_reg     <= {1'b0, vm30_next} + {1'b0, T_Q30};
            x3_reg     <= $signed({1'b0, u2_reg[31:2]}) - $signed({1'b0, S_Q30});
            m3_reg     <= mshift[30:0];
            lead3_reg  <= lead2_reg;
            u3_reg     <= u2_reg;
            neg3_reg   <= neg2_reg;
            usq3_reg   <= uu[59:30];

            pa4_reg    <= pa_next[29:0];
            pbm4_reg   <= pbm_next[29:0];
            xneg4_reg  <= x3_reg[30];
            xx4_reg    <= xx_next[29:0];
            vsq4_reg   <= vsq_next;
            y4_reg     <= y3_reg;
            m4_reg     <= m3_reg;
            lead4_reg  <= lead3_reg;
            u4_reg     <= u3_reg;
            neg4_reg   <= neg3_reg;
            usq4_reg   <= usq3_reg;
            vm32_4_reg <= vm32_3_reg;

            pym5_reg   <= pym_next[29:0];
            pyneg5_reg <= inner[31];
            xx5_reg    <= xx4_reg;
            vsq5_reg   <= vsq4_reg;
            m5_reg     <= m4_reg;
            lead5_reg  <= lead4_reg;
            u5_reg     <= u4_reg;
            neg5_reg   <= neg4_reg;
            usq5_reg   <= usq4_reg;
            vm32_5_reg <= vm32_4_reg;

            m6_reg           <= m5_reg;
            side6_reg.neg    <= neg5_reg;
            side6_reg.sq_acc <= q_sum < R1_Q30;
            side6_reg.sq_rej <= q_sum > R2_Q30;
            side6_reg.lead   <= lead5_reg;
            side6_reg.usq    <= usq5_reg;
            side6_reg.vsq    <= vsq5_reg;
            side6_reg.num    <= vm32_5_reg;
            side6_reg.den    <= u5_reg;

            e1_a_reg    <= a_next;
            e1_b_reg    <= fb[61:30];
            e1_side_reg <= lside_out;

            e2_nl_reg   <= nl_diff[37:2];
            e2_side_reg <= e1_side_reg;

            e3_plo_reg  <= {18'd0, e2_side_reg.usq} * {30'd0, e2_nl_reg[17:0]};
            e3_phi_reg  <= {18'd0, e2_side_reg.usq} * {30'd0, e2_nl_reg[35:18]};
            e3_side_reg <= e2_side_reg;

            e4_sum_reg  <= {e3_phi_reg, 18'd0} + {18'd0, e3_plo_reg};
            e4_side_reg <= e3_side_reg;

            e5_num_reg  <= e4_side_reg.num;
            e5_den_reg  <= e4_side_reg.den;
            e5_neg_reg  <= e4_side_reg.neg;
        end
    end

    // ---------------- output buffer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= sample_next;
    end

    // ---------------- checks ----------------
    a_zero_u_dropped : assert property (@(posedge clk) disable iff (!rst_n)
        (pairs.valid && pairs.ready && pairs.uniform_u == 32'd0) |=> !v1_reg)
        else $error("zero u word entered the pipeline");

    a_squeeze_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        v6_reg |-> !(side6_reg.sq_acc && side6_reg.sq_rej))
        else $error("squeeze both accepts and rejects");

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !push)
        else $error("output buffer overflow");

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop)
        else $error("output buffer underflow");

endmodule

`default_nettype wire

>>> rtl/grou_log.sv
// Log2 mantissa fraction by repeated squaring, one squaring per stage.
// Depends on grou_pkg.
`default_nettype none

module grou_log (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [30:0]         mant,
    input  wire grou_pkg::log_side_t in_side,
    output logic                     out_valid,
    output logic [29:0]              frac,
    output grou_pkg::log_side_t      out_side
);
    import grou_pkg::*;

    logic        vld_reg  [LOG_STAGES];
    logic [30:0] m_reg    [LOG_STAGES];
    logic [29:0] f_reg    [LOG_STAGES];
    log_side_t   side_reg [LOG_STAGES];

    for (genvar k = 0; k < LOG_STAGES; k++) begin : g_stage
        logic        vld_prev;
        logic [30:0] m_prev;
        logic [29:0] f_prev;
        log_side_t   side_prev;
        logic [61:0] sq;
        logic [31:0] t;
        logic [30:0] m_next;
        logic [29:0] f_next;

        if (k == 0) begin : g_first
            assign vld_prev  = in_valid;
            assign m_prev    = mant;
            assign f_prev    = '0;
            assign side_prev = in_side;
        end
        else begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign m_prev    = m_reg[k-1];
            assign f_prev    = f_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // square, keep the mantissa in [1,2), shift out one fraction bit
        always_comb
        begin
            sq     = {31'd0, m_prev} * {31'd0, m_prev};
            t      = sq[61:30];
            m_next = t[31] ? t[31:1] : t[30:0];
            f_next = {f_prev[28:0], t[31]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                m_reg[k]    <= m_next;
                f_reg[k]    <= f_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_valid = vld_reg[LOG_STAGES-1];
    assign frac      = f_reg[LOG_STAGES-1];
    assign out_side  = side_reg[LOG_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/grou_div.sv
// Restoring divider for the ratio v/u, one quotient bit per stage.
// Depends on grou_pkg.
`default_nettype none

module grou_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] num,
    input  wire logic [31:0] den,
    input  wire logic        in_neg,
    output logic             out_valid,
    output logic             out_neg,
    output logic             out_sat,
    output logic [21:0]      quo
);
    import grou_pkg::*;

    localparam int DW = 33 + FRAC_BITS;
    localparam int HW = DW - QUO_W;
    localparam int CW = (HW > 32) ? HW : 32;

    logic             vld_reg [QUO_W+1];
    logic             neg_reg [QUO_W+1];
    logic             sat_reg [QUO_W+1];
    logic [31:0]      den_reg [QUO_W+1];
    logic [31:0]      rem_reg [QUO_W+1];
    logic [QUO_W-1:0] low_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];

    logic [DW-1:0] dvd;
    logic [CW-1:0] hi_ext;
    logic [CW-1:0] den_ext;
    logic          sat_next;

    // any quotient at or above 2^22 saturates; otherwise the top part seeds the remainder
    always_comb
    begin
        dvd      = {num, {(FRAC_BITS+1){1'b0}}};
        hi_ext   = CW'(dvd >> QUO_W);
        den_ext  = CW'(den);
        sat_next = hi_ext >= den_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= in_neg;
            sat_reg[0] <= sat_next;
            den_reg[0] <= den;
            rem_reg[0] <= hi_ext[31:0];
            low_reg[0] <= dvd[QUO_W-1:0];
            quo_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [32:0] t;
        logic        ge;
        logic [32:0] diff;

        always_comb
        begin
            t    = {rem_reg[k-1], low_reg[k-1][QUO_W-1]};
            ge   = t >= {1'b0, den_reg[k-1]};
            diff = t - {1'b0, den_reg[k-1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[k] <= neg_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                rem_reg[k] <= ge ? diff[31:0] : t[31:0];
                low_reg[k] <= {low_reg[k-1][QUO_W-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][QUO_W-2:0], ge};
            end
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign out_neg   = neg_reg[QUO_W];
    assign out_sat   = sat_reg[QUO_W];
    assign quo       = quo_reg[QUO_W];

endmodule

`default_nettype wire

>>> tb/gaussian_ratio_of_uniforms_test.sv
// Self-checking testbench for the ratio-of-uniforms normal sampler.
// Depends on grou_pkg, grou_if and gaussian_ratio_of_uniforms; predicts every
// accepted pair with an exact fixed-point model and checks each output word.
`default_nettype none

module gaussian_ratio_of_uniforms_test;
    timeunit 1ns;
    timeprecision 1ps;

    import grou_pkg::*;

    // Fixed-point constants of the sampler, Q.30 unless named otherwise
    localparam longint unsigned SCALE_K    = 64'd1842111473;  // 1.7156
    localparam longint          CENTER_U   = 64'sd483045308;  // 0.449871
    localparam longint          OFFSET_V   = 64'sd415103221;  // 0.386595
    localparam longint          COEF_A     = 64'sd210453398;  // 0.19600
    localparam longint          COEF_B     = 64'sd273503517;  // 0.25472
    localparam longint          INNER_EDGE = 64'sd296320531;  // 0.27597
    localparam longint          OUTER_EDGE = 64'sd298994148;  // 0.27846
    localparam longint unsigned LN2_FX32   = 64'd2977044472;
    localparam longint unsigned SAMPLE_SAT = 64'd2097152;     // 2^21
    localparam longint unsigned POS_LIMIT  = 64'd1048575;
    localparam longint unsigned NEG_LIMIT  = 64'd1048576;
    localparam int              FRAC_BITS  = 16;
    localparam int              CYCLE_LIMIT = 600000;
    localparam int              DRAIN_CYCLES = 100;

    logic clk;
    logic rst_n;

    grou_in_if  pairs_if();
    grou_out_if samples_if();

    gaussian_ratio_of_uniforms #(.SAMPLE_FRACTION_BITS(FRAC_BITS)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pairs   (pairs_if),
        .samples (samples_if)
    );

    // Expected normal deviates, oldest first
    logic signed [20:0] expected_samples[$];

    int errors        = 0;
    int pairs_sent    = 0;
    int pairs_dropped = 0;
    int samples_seen  = 0;
    int cycle_count   = 0;
    int idle_pct      = 0;   // chance per cycle that the sender holds off
    int stall_pct     = 0;   // chance per cycle that the receiver stalls

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Signed Q.30 multiply done on magnitudes, rounded half up, re-signed
    function automatic longint fx_mul30(input longint a, input longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned p;
        begin
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            p = (ma * mb + (64'd1 << 29)) >> 30;
            return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
        end
    endfunction

    // -ln(word / 2^32) in Q.30 via leading one plus a squaring log2 chain
    function automatic longint unsigned neg_log_q30(input longint unsigned word);
        int unsigned lead;
        longint unsigned mant;
        longint unsigned frac;
        begin
            lead = 0;
            frac = 0;
            for (int i = 0; i < 32; i++)
                if (word[i])
                    lead = i;
            mant = (lead >= 30) ? (word >> (lead - 30)) : (word << (30 - lead));
            for (int i = 0; i < 30; i++)
            begin
                mant = (mant * mant) >> 30;
                frac = frac << 1;
                if (mant >= (64'd1 << 31))
                begin
                    mant = mant >> 1;
                    frac = frac | 64'd1;
                end
            end
            return ((longint'(32 - lead)) * LN2_FX32 - ((frac * LN2_FX32) >> 30)) >> 2;
        end
    endfunction

    // Returns 1 and the deviate when the pair is accepted, 0 when dropped
    function automatic bit predict_deviate(input logic [31:0] u_word,
                                           input logic [31:0] v_word,
                                           output logic signed [20:0] deviate);
        longint unsigned uw;
        longint unsigned dmag;
        longint unsigned vm62;
        longint unsigned vm32;
        longint unsigned vm30;
        longint unsigned u30;
        longint unsigned usq;
        longint unsigned bound;
        longint unsigned quo;
        longint unsigned rem;
        longint unsigned mag;
        longint x;
        longint y;
        longint inner;
        longint q;
        bit vneg;
        bit accept;
        begin
            deviate = '0;
            uw = u_word;
            if (uw == 0)
                return 0;
            vneg = (v_word < 32'h8000_0000);
            dmag = vneg ? (64'h8000_0000 - v_word) : (v_word - 64'h8000_0000);
            vm62 = dmag * SCALE_K;
            vm32 = (vm62 + (64'd1 << 29)) >> 30;
            vm30 = (vm62 + (64'd1 << 31)) >> 32;

            // Quadratic squeeze first, exact log test only in the band
            x = longint'(uw >> 2) - CENTER_U;
            y = longint'(vm30) + OFFSET_V;
            inner = fx_mul30(COEF_A, y) - fx_mul30(COEF_B, x);
            q = fx_mul30(x, x) + fx_mul30(y, inner);
            if (q < INNER_EDGE)
                accept = 1;
            else if (q > OUTER_EDGE)
                accept = 0;
            else
            begin
                u30 = uw >> 2;
                usq = (u30 * u30) >> 30;
                bound = 64'd4 * usq * neg_log_q30(uw);
                accept = (vm30 * vm30 <= bound);
            end
            if (!accept)
                return 0;

            // Restoring division, round half away from zero, saturate
            quo = vm32 / uw;
            rem = vm32 % uw;
            if (quo >= SAMPLE_SAT)
                mag = SAMPLE_SAT;
            else
            begin
                mag = quo;
                for (int i = 0; i < FRAC_BITS; i++)
                begin
                    rem = rem << 1;
                    mag = mag << 1;
                    if (rem >= uw)
                    begin
                        rem = rem - uw;
                        mag = mag | 64'd1;
                    end
                    if (mag >= SAMPLE_SAT)
                    begin
                        mag = SAMPLE_SAT;
                        break;
                    end
                end
                if (mag < SAMPLE_SAT && (rem << 1) >= uw)
                    mag = mag + 1;
            end
            if (vneg)
            begin
                if (mag > NEG_LIMIT)
                    mag = NEG_LIMIT;
                deviate = 21'(64'd0 - mag);
            end
            else
            begin
                if (mag > POS_LIMIT)
                    mag = POS_LIMIT;
                deviate = 21'(mag);
            end
            return 1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Drive every input to a known value before the first edge
    initial
    begin
        rst_n = 1'b0;
        pairs_if.valid = 1'b0;
        pairs_if.uniform_u = '0;
        pairs_if.uniform_v = '0;
        samples_if.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Kill a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d samples outstanding",
                     cycle_count, expected_samples.size());
            $display("[gaussian_ratio_of_uniforms] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure and output check
    // ------------------------------------------------------------------

    // Drop ready at random, per the current stall rate
    always @(negedge clk)
        if (rst_n)
            samples_if.ready <= ($urandom_range(99) >= stall_pct);

    // Compare each accepted output word with the oldest expectation
    always @(posedge clk)
    begin
        logic signed [20:0] want;
        if (rst_n && samples_if.valid && samples_if.ready)
        begin
            samples_seen++;
            if (expected_samples.size() == 0)
            begin
                $error("unexpected sample: normal_sample actual %0d",
                       samples_if.normal_sample);
                errors++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (samples_if.normal_sample !== want)
                begin
                    $error("mismatch: normal_sample expected %0d actual %0d",
                           want, samples_if.normal_sample);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one candidate pair, hold it until taken, then predict it
    task automatic send_pair(input logic [31:0] u_word, input logic [31:0] v_word);
        logic signed [20:0] deviate;
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                pairs_if.valid <= 1'b0;
                @(negedge clk);
            end
            pairs_if.valid <= 1'b1;
            pairs_if.uniform_u <= u_word;
            pairs_if.uniform_v <= v_word;
            do
                @(posedge clk);
            while (!pairs_if.ready);
            pairs_sent++;
            if (predict_deviate(u_word, v_word, deviate))
                expected_samples.push_back(deviate);
            else
                pairs_dropped++;
            @(negedge clk);
        end
    endtask

    // Release the channel, wait for every expected word, then let the pipe settle
    task automatic drain_pipeline();
        begin
            pairs_if.valid <= 1'b0;
            wait (expected_samples.size() == 0);
            repeat (DRAIN_CYCLES) @(posedge clk);
            @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, zero u, v at center, tiny u (saturation side), squeeze band
    task automatic test_directed_corners();
        begin
            idle_pct = 0;
            stall_pct = 0;
            send_pair(32'h0000_0000, 32'h1234_5678);  // zero u word, dropped
            send_pair(32'h0000_0000, 32'hFFFF_FFFF);
            send_pair(32'hFFFF_FFFF, 32'h8000_0000);  // v exactly zero
            send_pair(32'hFFFF_FFFF, 32'h0000_0000);  // most negative v
            send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // most positive v
            send_pair(32'h8000_0000, 32'h8000_0001);
            send_pair(32'h8000_0000, 32'h7FFF_FFFF);
            send_pair(32'h0000_0001, 32'h8000_0000);  // tiny u
            send_pair(32'h0000_0001, 32'h8000_0001);
            send_pair(32'h0000_0002, 32'h7FFF_FFFF);
            send_pair(32'h0000_FFFF, 32'h8000_0100);
            send_pair(32'h0100_0000, 32'h8100_0000);
            send_pair(32'h7332_0000, 32'hC000_0000);  // around the squeeze band
            send_pair(32'h7332_0000, 32'h4000_0000);
            send_pair(32'h4000_0000, 32'hA000_0000);
            send_pair(32'h2000_0000, 32'h9000_0000);
            send_pair(32'hC000_0000, 32'hF000_0000);
            send_pair(32'h5555_5555, 32'hAAAA_AAAA);
            send_pair(32'hAAAA_AAAA, 32'h5555_5555);
            send_pair(32'h0000_8000, 32'h8000_8000);
            drain_pipeline();
        end
    endtask

    // Random pairs: mostly full-range, some small or zero u and near-center v
    task automatic test_random_pairs(input int n_pairs, input int idle, input int stall);
        logic [31:0] u_word;
        logic [31:0] v_word;
        int pick;
        begin
            idle_pct = idle;
            stall_pct = stall;
            for (int i = 0; i < n_pairs; i++)
            begin
                pick = $urandom_range(99);
                u_word = $urandom;
                v_word = $urandom;
                if (pick < 10)
                    u_word = u_word >> $urandom_range(31);
                else if (pick < 15)
                    u_word = '0;
                else if (pick < 22)
                    v_word = 32'h8000_0000 + ($urandom >> $urandom_range(31, 4));
                send_pair(u_word, v_word);
            end
            drain_pipeline();
        end
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);
        test_directed_corners();
        test_random_pairs(410, 0, 0);
        test_random_pairs(410, 76, 0);
        test_random_pairs(410, 0, 76);
        test_random_pairs(410, 14, 14);

        $display("sent %0d candidate pairs (%0d dropped), checked %0d deviates",
                 pairs_sent, pairs_dropped, samples_seen);
        $display("phases: corners, free-running, sender gaps, receiver stalls, mixed");
        if (errors == 0)
            $display("[gaussian_ratio_of_uniforms] OK");
        else
            $display("[gaussian_ratio_of_uniforms] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
